@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tsc_pkg.sv @@
// Types and constants of the touch sample conditioner.
package tsc_pkg;

   // field widths
   localparam int RAW_W       = 15;
   localparam int PRESS_W     = 13;
   localparam int AXIS_W      = 11;
   localparam int POS_W       = 12;
   localparam int ORIENT_W    = 3;
   localparam int SIZE_IDX_W  = 4;    // bit index into a 12-bit screen size
   localparam int DIV_W       = 23;   // product of 11-bit offset and 12-bit size
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [AXIS_W-1:0] axis_type;
   typedef logic [2:0]        reg_idx_type;

   // register indexes
   localparam reg_idx_type REG_PRESS_THR = 3'd0;
   localparam reg_idx_type REG_X_MIN     = 3'd1;
   localparam reg_idx_type REG_X_MAX     = 3'd2;
   localparam reg_idx_type REG_Y_MIN     = 3'd3;
   localparam reg_idx_type REG_Y_MAX     = 3'd4;
   localparam reg_idx_type REG_SCR_W     = 3'd5;
   localparam reg_idx_type REG_SCR_H     = 3'd6;
   localparam reg_idx_type REG_ORIENT    = 3'd7;

   // register reset values
   localparam logic [PRESS_W-1:0]  PRESS_THR_RST = 13'd400;
   localparam axis_type            X_MIN_RST     = 11'd200;
   localparam axis_type            X_MAX_RST     = 11'd1950;
   localparam axis_type            Y_MIN_RST     = 11'd200;
   localparam axis_type            Y_MAX_RST     = 11'd1860;
   localparam pos_type             SCR_W_RST     = 12'd320;
   localparam pos_type             SCR_H_RST     = 12'd240;
   localparam logic [ORIENT_W-1:0] ORIENT_RST    = 3'd0;

   // orientation flag bits
   localparam int ORIENT_SWAP  = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   localparam logic [PRESS_W-1:0] PRESS_BIAS = 13'd4096;
   localparam pos_type            POS_MAX    = 12'hFFF;

endpackage

@@ design/touch_sample_conditioner_top.sv @@
// Touch sample conditioner: pressure detect, calibrate, scale and window average.
// An untouched word goes from idle straight to the response register. A touched word passes
// the bit-serial multiplier and the shared divider for each axis, then the window walk and the
// averaging divides; an axis whose max is not above its min skips its mapping divide.
// One word is in work at a time; the next is taken once the last response is registered.
// Reset (synchronous, active high) restores register defaults and empties the window.
module touch_sample_conditioner_top import tsc_pkg::*; #(
   parameter int WINDOW_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // z1_word, z2_word, x_word, y_word, pad
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // x_pos, y_pos
   output logic                   rsp_tuser,   // touched
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int CW     = $clog2(WINDOW_DEPTH + 1);           // fill count width
   localparam int IW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SW     = POS_W + $clog2(WINDOW_DEPTH);       // window sum width
   localparam int DCNT_W = $clog2(DIV_W);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;  // serial off*size, MSB of size first
   localparam logic [2:0] S_DIV   = 3'd2;  // restoring divide, one bit per cycle
   localparam logic [2:0] S_MAP   = 3'd3;  // saturate and invert
   localparam logic [2:0] S_SUM   = 3'd4;  // walk the window
   localparam logic [2:0] S_AVGLD = 3'd5;  // load a sum into the divider
   localparam logic [2:0] S_DONE  = 3'd6;

   // work phases
   localparam logic [1:0] PH_MAP_X = 2'd0;
   localparam logic [1:0] PH_MAP_Y = 2'd1;
   localparam logic [1:0] PH_AVG_X = 2'd2;
   localparam logic [1:0] PH_AVG_Y = 2'd3;

   // ---------------------------------------------------------------- registers
   logic [PRESS_W-1:0]  thr_ff;
   axis_type            xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   pos_type             scrw_ff, scrh_ff;
   logic [ORIENT_W-1:0] orient_ff;
   logic                csr_wr;
   reg_idx_type         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= PRESS_THR_RST;
         xmin_ff   <= X_MIN_RST;
         xmax_ff   <= X_MAX_RST;
         ymin_ff   <= Y_MIN_RST;
         ymax_ff   <= Y_MAX_RST;
         scrw_ff   <= SCR_W_RST;
         scrh_ff   <= SCR_H_RST;
         orient_ff <= ORIENT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PRESS_THR: thr_ff    <= csr_pwdata[PRESS_W-1:0];
            REG_X_MIN:     xmin_ff   <= csr_pwdata[AXIS_W-1:0];
            REG_X_MAX:     xmax_ff   <= csr_pwdata[AXIS_W-1:0];
            REG_Y_MIN:     ymin_ff   <= csr_pwdata[AXIS_W-1:0];
            REG_Y_MAX:     ymax_ff   <= csr_pwdata[AXIS_W-1:0];
            REG_SCR_W:     scrw_ff   <= csr_pwdata[POS_W-1:0];
            REG_SCR_H:     scrh_ff   <= csr_pwdata[POS_W-1:0];
            REG_ORIENT:    orient_ff <= csr_pwdata[ORIENT_W-1:0];
            default:       thr_ff    <= thr_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_PRESS_THR: csr_prdata = CSR_DATA_W'(thr_ff);
         REG_X_MIN:     csr_prdata = CSR_DATA_W'(xmin_ff);
         REG_X_MAX:     csr_prdata = CSR_DATA_W'(xmax_ff);
         REG_Y_MIN:     csr_prdata = CSR_DATA_W'(ymin_ff);
         REG_Y_MAX:     csr_prdata = CSR_DATA_W'(ymax_ff);
         REG_SCR_W:     csr_prdata = CSR_DATA_W'(scrw_ff);
         REG_SCR_H:     csr_prdata = CSR_DATA_W'(scrh_ff);
         REG_ORIENT:    csr_prdata = CSR_DATA_W'(orient_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- front end
   logic [RAW_W-1:0]   z1_word, z2_word, x_word, y_word;
   logic [PRESS_W-1:0] press;
   logic               touch_hit;
   axis_type           raw_a, raw_b, off_a, off_b;

   assign z1_word = req_tdata[RAW_W-1:0];
   assign z2_word = req_tdata[2*RAW_W-1:RAW_W];
   assign x_word  = req_tdata[3*RAW_W-1:2*RAW_W];
   assign y_word  = req_tdata[4*RAW_W-1:3*RAW_W];

   // (z1>>3) + 4096 - (z2>>3), always 1..8191
   assign press = PRESS_W'({1'b0, z1_word[RAW_W-1:3]}) + PRESS_BIAS
                - PRESS_W'({1'b0, z2_word[RAW_W-1:3]});
   assign touch_hit = press > thr_ff;

   // 11-bit position, optional swap
   assign raw_a = orient_ff[ORIENT_SWAP] ? y_word[RAW_W-1:4] : x_word[RAW_W-1:4];
   assign raw_b = orient_ff[ORIENT_SWAP] ? x_word[RAW_W-1:4] : y_word[RAW_W-1:4];
   assign off_a = (raw_a > xmin_ff) ? raw_a - xmin_ff : '0;
   assign off_b = (raw_b > ymin_ff) ? raw_b - ymin_ff : '0;

   // ---------------------------------------------------------------- datapath state
   logic [2:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dq_ff, dq_in;      // product, then dividend/quotient shifter
   axis_type          rem_ff, rem_in;
   axis_type          offx_ff, offx_in, offy_ff, offy_in;
   pos_type           sx_ff, sx_in;
   pos_type           win_x_ff [WINDOW_DEPTH];
   pos_type           win_x_in [WINDOW_DEPTH];
   pos_type           win_y_ff [WINDOW_DEPTH];
   pos_type           win_y_in [WINDOW_DEPTH];
   logic [CW-1:0]     fill_ff, fill_in, idx_ff, idx_in;
   logic [SW-1:0]     sumx_ff, sumx_in, sumy_ff, sumy_in;
   pos_type           held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic              touched_ff, touched_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   // axis selection while mapping
   logic              axis_y;
   axis_type          cur_off, cur_lo, cur_hi, span, divisor;
   pos_type           cur_size, sat_v, inv_v, mapped;
   logic              cur_inv, span_ok;
   logic [DIV_W-1:0]  mul_nx, div_nx;
   logic [AXIS_W:0]   rem_t;
   logic              div_ge;
   axis_type          rem_nx;
   logic [SW-1:0]     avg_sum;

   assign axis_y   = phase_ff[0];
   assign cur_off  = axis_y ? offy_ff : offx_ff;
   assign cur_lo   = axis_y ? ymin_ff : xmin_ff;
   assign cur_hi   = axis_y ? ymax_ff : xmax_ff;
   assign cur_size = axis_y ? scrh_ff : scrw_ff;
   assign cur_inv  = axis_y ? orient_ff[ORIENT_INV_Y] : orient_ff[ORIENT_INV_X];
   assign span_ok  = cur_hi > cur_lo;
   assign span     = cur_hi - cur_lo;
   assign divisor  = phase_ff[1] ? AXIS_W'(fill_ff) : span;

   // one shift-add step of the multiplier
   assign mul_nx = {dq_ff[DIV_W-2:0], 1'b0}
                 + (cur_size[cnt_ff[SIZE_IDX_W-1:0]] ? DIV_W'(cur_off) : '0);

   // one restoring divide step
   assign rem_t  = {rem_ff, dq_ff[DIV_W-1]};
   assign div_ge = rem_t >= {1'b0, divisor};
   assign rem_nx = div_ge ? AXIS_W'(rem_t - {1'b0, divisor}) : rem_t[AXIS_W-1:0];
   assign div_nx = {dq_ff[DIV_W-2:0], div_ge};

   // saturate at 4095, then optional inversion against the screen size
   assign sat_v  = (|dq_ff[DIV_W-1:POS_W]) ? POS_MAX : dq_ff[POS_W-1:0];
   assign inv_v  = (sat_v >= cur_size) ? '0 : cur_size - sat_v;
   assign mapped = cur_inv ? inv_v : sat_v;

   assign avg_sum = (phase_ff == PH_AVG_X) ? sumx_ff : sumy_ff;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      offx_in       = offx_ff;
      offy_in       = offy_ff;
      sx_in         = sx_ff;
      win_x_in      = win_x_ff;
      win_y_in      = win_y_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      sumx_in       = sumx_ff;
      sumy_in       = sumy_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      touched_in    = touched_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (touch_hit) begin
                  offx_in  = off_a;
                  offy_in  = off_b;
                  phase_in = PH_MAP_X;
                  dq_in    = '0;
                  cnt_in   = DCNT_W'(POS_W - 1);
                  state_in = S_MUL;
               end else begin
                  // no touch: window emptied, held position repeated
                  fill_in    = '0;
                  touched_in = 1'b0;
                  state_in   = S_DONE;
               end
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff - 1'b1;
            dq_in  = mul_nx;
            if (cnt_ff == '0) begin
               rem_in = '0;
               cnt_in = DCNT_W'(DIV_W - 1);
               if (span_ok) begin
                  state_in = S_DIV;
               end else begin
                  dq_in    = '0;
                  state_in = S_MAP;
               end
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            dq_in  = div_nx;
            rem_in = rem_nx;
            if (cnt_ff == '0) begin
               case (phase_ff)
                  PH_AVG_X: begin
                     held_x_in = div_nx[POS_W-1:0];
                     phase_in  = PH_AVG_Y;
                     state_in  = S_AVGLD;
                  end
                  PH_AVG_Y: begin
                     held_y_in  = div_nx[POS_W-1:0];
                     touched_in = 1'b1;
                     state_in   = S_DONE;
                  end
                  default: state_in = S_MAP;
               endcase
            end
         end
         S_MAP: begin
            if (!axis_y) begin
               sx_in    = mapped;
               phase_in = PH_MAP_Y;
               dq_in    = '0;
               cnt_in   = DCNT_W'(POS_W - 1);
               state_in = S_MUL;
            end else begin
               for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
                  win_x_in[i] = win_x_ff[i-1];
                  win_y_in[i] = win_y_ff[i-1];
               end
               win_x_in[0] = sx_ff;
               win_y_in[0] = mapped;
               if (fill_ff < CW'(WINDOW_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               sumx_in  = '0;
               sumy_in  = '0;
               idx_in   = '0;
               phase_in = PH_AVG_X;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sumx_in = sumx_ff + SW'(win_x_ff[idx_ff[IW-1:0]]);
            sumy_in = sumy_ff + SW'(win_y_ff[idx_ff[IW-1:0]]);
            idx_in  = idx_ff + 1'b1;
            if (idx_ff + 1'b1 == fill_ff) begin
               state_in = S_AVGLD;
            end
         end
         S_AVGLD: begin
            // sum left-aligned: after SW steps the low bits hold the quotient
            dq_in    = {avg_sum, {(DIV_W - SW){1'b0}}};
            rem_in   = '0;
            cnt_in   = DCNT_W'(SW - 1);
            state_in = S_DIV;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_data_in   = {held_y_ff, held_x_ff};
               rsp_user_in   = touched_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         held_x_ff     <= '0;
         held_y_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      cnt_ff      <= cnt_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      offx_ff     <= offx_in;
      offy_ff     <= offy_in;
      sx_ff       <= sx_in;
      win_x_ff    <= win_x_in;
      win_y_ff    <= win_y_in;
      idx_ff      <= idx_in;
      sumx_ff     <= sumx_in;
      sumy_ff     <= sumy_in;
      touched_ff  <= touched_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/tsc_checker.sv @@
// Port-level checker for the touch sample conditioner, bound to the top level.
`include "assert_macros.svh"

module tsc_checker import tsc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   logic                   in_acc, out_acc;
   logic [1:0]             pend_ff, pend_in;
   logic [RSP_TDATA_W-1:0] last_ff, last_in;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff + 2'(in_acc) - 2'(out_acc);
      last_in = out_acc ? rsp_tdata : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         last_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         last_ff <= last_in;
      end
   end

   `TSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response word changed while stalled")
   `TSC_ASSERT_NOW(a_no_orphan, clock, reset, out_acc, pend_ff != 2'd0, "response word without a request word")
   `TSC_ASSERT_NEXT(a_busy_after_take, clock, reset, in_acc, !req_tready, "request taken while a word is in work")
   `TSC_ASSERT_NOW(a_hold_repeat, clock, reset, out_acc && !rsp_tuser, rsp_tdata == last_ff, "untouched word did not repeat held position")

endmodule

bind touch_sample_conditioner_top tsc_checker u_tsc_checker (.*);
